@@ rtl/core/cbd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and the covalent radius table of the bond detector.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int MaxAtomsDefault = 64;
  localparam int CoordW          = 18;
  localparam int ElemW           = 4;
  localparam int RadW            = 8;
  localparam int ScaleW          = 10;
  localparam int OutIdxW         = 6;
  localparam int D2W             = 38;
  localparam int TmW             = 19;

  localparam logic [ScaleW-1:0] RadiusScaleReset = 10'd307;
  localparam logic [D2W-1:0]    MaxD2            = 38'd90000;

  localparam logic [ElemW-1:0] ElemH  = 4'd0;
  localparam logic [ElemW-1:0] ElemC  = 4'd1;
  localparam logic [ElemW-1:0] ElemN  = 4'd2;
  localparam logic [ElemW-1:0] ElemO  = 4'd3;
  localparam logic [ElemW-1:0] ElemF  = 4'd4;
  localparam logic [ElemW-1:0] ElemP  = 4'd5;
  localparam logic [ElemW-1:0] ElemS  = 4'd6;
  localparam logic [ElemW-1:0] ElemCl = 4'd7;
  localparam logic [ElemW-1:0] ElemBr = 4'd8;
  localparam logic [ElemW-1:0] ElemI  = 4'd9;
  localparam logic [ElemW-1:0] ElemSi = 4'd10;
  localparam logic [ElemW-1:0] ElemB  = 4'd11;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadW-1:0]          rad;
  } atom_t;

  typedef struct packed {
    logic               found;
    logic [OutIdxW-1:0] earlier_index;
    logic [OutIdxW-1:0] new_index;
    logic               last;
    logic               overflow;
  } bond_t;

  // radius in hundredths of an angstrom
  function automatic logic [RadW-1:0] radius_of(input logic [ElemW-1:0] elem);
    logic [RadW-1:0] r;
    unique case (elem)
      ElemH:   r = 8'd31;
      ElemC:   r = 8'd76;
      ElemN:   r = 8'd71;
      ElemO:   r = 8'd66;
      ElemF:   r = 8'd57;
      ElemP:   r = 8'd107;
      ElemS:   r = 8'd105;
      ElemCl:  r = 8'd102;
      ElemBr:  r = 8'd120;
      ElemI:   r = 8'd139;
      ElemSi:  r = 8'd111;
      ElemB:   r = 8'd84;
      default: r = 8'd100;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/cbd_if.sv @@
// ----------------------------------------------------------------------------
// cbd_if
// Valid/ready channels for atom items and bond result items.
// ----------------------------------------------------------------------------
interface cbd_in_if;
  import cbd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     first_atom;
  logic [ElemW-1:0]         element;
  logic signed [CoordW-1:0] pos_x;
  logic signed [CoordW-1:0] pos_y;
  logic signed [CoordW-1:0] pos_z;

  modport source (output valid, first_atom, element, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, first_atom, element, pos_x, pos_y, pos_z, output ready);
endinterface

interface cbd_out_if;
  import cbd_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [OutIdxW-1:0] earlier_index;
  logic [OutIdxW-1:0] new_index;
  logic               last;
  logic               overflow;

  modport source (output valid, found, earlier_index, new_index, last, overflow,
                  input ready);
  modport sink   (input valid, found, earlier_index, new_index, last, overflow,
                  output ready);
endinterface

@@ rtl/core/cbd_ram.sv @@
// ----------------------------------------------------------------------------
// cbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/cbd_fifo.sv @@
// ----------------------------------------------------------------------------
// cbd_fifo
// Two-entry queue between the classifying front and the scanning back.
// ----------------------------------------------------------------------------
module cbd_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] slot_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/cbd_front.sv @@
// ----------------------------------------------------------------------------
// cbd_front
// Accepts atom items, keeps the atom count, assigns the index, flags overflow
// and looks up the radius.
// ----------------------------------------------------------------------------
module cbd_front import cbd_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault,
  parameter int IdxW     = $clog2(MaxAtoms)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cbd_in_if.sink          atom_i,
  input  logic            q_full_i,
  output logic            push_o,
  output logic            ovf_o,
  output logic [IdxW-1:0] idx_o,
  output atom_t           atom_o
);

  localparam logic [IdxW:0] MaxCnt = (IdxW+1)'(MaxAtoms);

  logic [IdxW:0] count_q, count_d, base;

  assign atom_i.ready = !q_full_i;
  assign push_o       = atom_i.valid && !q_full_i;

  assign base   = atom_i.first_atom ? '0 : count_q;
  assign ovf_o  = (base >= MaxCnt);
  assign idx_o  = base[IdxW-1:0];
  assign atom_o = '{x: atom_i.pos_x, y: atom_i.pos_y, z: atom_i.pos_z,
                    rad: radius_of(atom_i.element)};

  always_comb begin
    count_d = count_q;
    if (push_o) begin
      count_d = ovf_o ? base : base + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ rtl/core/cbd_back.sv @@
// ----------------------------------------------------------------------------
// cbd_back
// Scans the stored atoms against the current one through a three-stage
// distance pipeline and emits the bonded pairs and a last item, then stores the atom unless it overflowed.
// ----------------------------------------------------------------------------
module cbd_back import cbd_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault,
  parameter int IdxW     = $clog2(MaxAtoms)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ScaleW-1:0] scale_i,
  input  logic              cmd_valid_i,
  input  logic              cmd_ovf_i,
  input  logic [IdxW-1:0]   cmd_idx_i,
  input  atom_t             cmd_atom_i,
  output logic              pop_o,
  cbd_out_if.source         bond_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]    st_q;
  logic          cur_ovf_q;
  logic [IdxW-1:0] cur_n_q;
  atom_t         cur_q;
  logic [IdxW:0] i_q;

  logic            v1_q, v2_q, v3_q;
  logic [IdxW-1:0] idx1_q, idx2_q, idx3_q;
  logic [2*CoordW-1:0] sqx_q, sqy_q, sqz_q;
  logic [TmW-1:0]  tm_q;
  logic [D2W-1:0]  d2_q, t2_q;

  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;

  logic  ov_q;
  bond_t out_q;

  logic  adv, issue, bond, drained, ov_set;
  atom_t rd;
  logic [IdxW-1:0] raddr;
  logic [CoordW:0] dx, dy, dz, ax, ay, az;
  logic [2*CoordW-1:0] sqx_d, sqy_d, sqz_d;
  logic [RadW:0]   rsum;
  logic [TmW-1:0]  tm_d;
  logic [D2W-1:0]  t2_d;
  logic [D2W+15:0] lhs;

  assign adv     = !ov_q || bond_o.ready;
  assign issue   = (st_q == StScan) && (i_q < {1'b0, cur_n_q});
  assign drained = !v1_q && !v2_q && !v3_q;
  assign pop_o   = (st_q == StIdle) && cmd_valid_i;
  assign raddr   = adv ? i_q[IdxW-1:0] : idx1_q;
  assign ov_set  = adv && ((bond && pend_q) || (st_q == StFinish));

  cbd_ram #(.Width($bits(atom_t)), .Depth(MaxAtoms)) u_store (
    .clk_i   (clk_i),
    .we_i    ((st_q == StFinish) && adv && !cur_ovf_q),
    .waddr_i (cur_n_q),
    .wdata_i (cur_q),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  always_comb begin
    dx    = {cur_q.x[CoordW-1], cur_q.x} - {rd.x[CoordW-1], rd.x};
    dy    = {cur_q.y[CoordW-1], cur_q.y} - {rd.y[CoordW-1], rd.y};
    dz    = {cur_q.z[CoordW-1], cur_q.z} - {rd.z[CoordW-1], rd.z};
    ax    = dx[CoordW] ? -dx : dx;
    ay    = dy[CoordW] ? -dy : dy;
    az    = dz[CoordW] ? -dz : dz;
    sqx_d = ax[CoordW-1:0] * ax[CoordW-1:0];
    sqy_d = ay[CoordW-1:0] * ay[CoordW-1:0];
    sqz_d = az[CoordW-1:0] * az[CoordW-1:0];
    rsum  = {1'b0, rd.rad} + {1'b0, cur_q.rad};
    tm_d  = TmW'(rsum * scale_i);
    t2_d  = D2W'(tm_q * tm_q);
    lhs   = {d2_q, 16'd0};
    bond  = v3_q && (lhs < {16'd0, t2_q}) && (d2_q < MaxD2);
  end

  assign bond_o.valid         = ov_q;
  assign bond_o.found         = out_q.found;
  assign bond_o.earlier_index = out_q.earlier_index;
  assign bond_o.new_index     = out_q.new_index;
  assign bond_o.last          = out_q.last;
  assign bond_o.overflow      = out_q.overflow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      i_q    <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      ov_q <= ov_set || (ov_q && !bond_o.ready);
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        if (issue) begin
          i_q <= i_q + 1'b1;
        end
        if (bond) begin
          pend_q <= 1'b1;
        end
      end
      unique case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            i_q  <= '0;
            st_q <= cmd_ovf_i ? StFinish : StScan;
          end
        end
        StScan: begin
          if (adv && !issue && drained) begin
            st_q <= StFinish;
          end
        end
        StFinish: begin
          if (adv) begin
            pend_q <= 1'b0;
            st_q   <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_ovf_q <= cmd_ovf_i;
      cur_n_q   <= cmd_idx_i;
      cur_q     <= cmd_atom_i;
    end
    if (adv) begin
      idx1_q <= i_q[IdxW-1:0];
      idx2_q <= idx1_q;
      idx3_q <= idx2_q;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      sqz_q  <= sqz_d;
      tm_q   <= tm_d;
      d2_q   <= D2W'(sqx_q) + D2W'(sqy_q) + D2W'(sqz_q);
      t2_q   <= t2_d;
      if (bond) begin
        pend_idx_q <= idx3_q;
        out_q      <= '{found: 1'b1, earlier_index: OutIdxW'(pend_idx_q),
                        new_index: OutIdxW'(cur_n_q), last: 1'b0, overflow: 1'b0};
      end
      if (st_q == StFinish) begin
        if (cur_ovf_q) begin
          out_q <= '{found: 1'b0, earlier_index: '0, new_index: '0,
                     last: 1'b1, overflow: 1'b1};
        end else if (pend_q) begin
          out_q <= '{found: 1'b1, earlier_index: OutIdxW'(pend_idx_q),
                     new_index: OutIdxW'(cur_n_q), last: 1'b1, overflow: 1'b0};
        end else begin
          out_q <= '{found: 1'b0, earlier_index: '0,
                     new_index: OutIdxW'(cur_n_q), last: 1'b1, overflow: 1'b0};
        end
      end
    end
  end

endmodule

@@ rtl/core/covalent_bond_detector_core.sv @@
// ----------------------------------------------------------------------------
// covalent_bond_detector_core
// Covalent-radius bond finder: stores atoms and reports bonded pairs.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// atom_i    in   valid/ready    first_atom, element, pos_x, pos_y, pos_z
// bond_o    out  valid/ready    found, earlier_index, new_index, last, overflow
// cfg       in   cfg_we_i       cfg_wdata_i (radius_scale)
//
// An atom with index n > 0 is scanned in the back end against the stored atoms,
// one stored atom a cycle while no result stalls, through the store's read port
// and a three-stage distance pipeline. Index 0 and a dropped atom are not
// scanned. Up to two atoms queue behind the one in the back end. Reset clears
// the atom count and the queue at once; the store is not cleared. A stalled
// result freezes the scan; items are still taken while the queue has room.
module covalent_bond_detector_core import cbd_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ScaleW-1:0] cfg_wdata_i,
  cbd_in_if.sink            atom_i,
  cbd_out_if.source         bond_o
);

  localparam int IdxW = $clog2(MaxAtoms);
  localparam int QW   = 1 + IdxW + $bits(atom_t);

  logic [ScaleW-1:0] scale_q;
  logic              q_full, push, ovf, q_valid, pop;
  logic [IdxW-1:0]   idx;
  atom_t             atom;
  logic [QW-1:0]     q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= RadiusScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  cbd_front #(.MaxAtoms(MaxAtoms), .IdxW(IdxW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .atom_i   (atom_i),
    .q_full_i (q_full),
    .push_o   (push),
    .ovf_o    (ovf),
    .idx_o    (idx),
    .atom_o   (atom)
  );

  cbd_fifo #(.Width(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({ovf, idx, atom}),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_out)
  );

  cbd_back #(.MaxAtoms(MaxAtoms), .IdxW(IdxW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .cmd_valid_i (q_valid),
    .cmd_ovf_i   (q_out[QW-1]),
    .cmd_idx_i   (q_out[QW-2 -: IdxW]),
    .cmd_atom_i  (q_out[$bits(atom_t)-1:0]),
    .pop_o       (pop),
    .bond_o      (bond_o)
  );

endmodule
